### src/gap_pkg.sv
// Shared types, constants and a helper function of the grid path planner.
package gap_pkg;

    localparam int GRID_SIZE = 8;
    localparam int CELL_AW   = 6;
    localparam int CELLS     = 64;
    localparam logic [3:0] GRID_LIM = 4'(GRID_SIZE);
    localparam logic [7:0] EDGE_COST_RST = 8'd10;
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PLAN  = 1'b1;
    localparam logic [1:0] DIR_XM = 2'd0;
    localparam logic [1:0] DIR_YM = 2'd1;
    localparam logic [1:0] DIR_XP = 2'd2;
    localparam logic [1:0] DIR_YP = 2'd3;
    localparam logic [2:0] ADDR_EDGE_COST = 3'd0;

    typedef struct packed {
        logic       req_type;
        logic [2:0] cell_x;
        logic [2:0] cell_y;
        logic       blocked;
        logic [2:0] start_x;
        logic [2:0] start_y;
        logic [2:0] goal_x;
        logic [2:0] goal_y;
    } in_t;

    typedef struct packed {
        logic [2:0] pos_x;
        logic [2:0] pos_y;
        logic       found;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [13:0] g;
        logic [14:0] f;
        logic [1:0]  dir;
        logic [5:0]  ord;
    } rec_t;

    function automatic logic [14:0] heur(input logic [2:0] x, input logic [2:0] y,
                                         input logic [2:0] gx, input logic [2:0] gy,
                                         input logic [7:0] ec);
        logic [2:0] ax;
        logic [2:0] ay;
        logic [3:0] s;
        logic [11:0] p;
        ax = (gx > x) ? gx - x : x - gx;
        ay = (gy > y) ? gy - y : y - gy;
        s = {1'b0, ax} + {1'b0, ay};
        p = {4'b0, ec} * {8'b0, s};
        return {3'b0, p};
    endfunction

endpackage

### src/gap_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
module gap_ram #(
    parameter int W  = 8,
    parameter int AW = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);
    logic [W-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/grid_astar_path_planner_unit.sv
// Top level of the grid A* path planner: control sequencer, status bits and memories.
// A write item updates the occupancy map without leaving the idle state; busy stays low.
// A plan item runs up to 64 expansions, each a scan of the cell record memory followed
// by a check of each neighbor, then traces the path back cell by cell and outputs it.
// Results are issued without a ready handshake and cannot be stalled.
// Reset clears occupancy, status bits and the edge cost (to 10); memories are not cleared.
module grid_astar_path_planner_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  gap_pkg::in_t      req,
    output logic              valid,
    output gap_pkg::out_t     res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_NBR  = 3'd2;
    localparam logic [2:0] S_NUPD = 3'd3;
    localparam logic [2:0] S_TWR  = 3'd4;
    localparam logic [2:0] S_TRD  = 3'd5;
    localparam logic [2:0] S_ERD  = 3'd6;
    localparam logic [2:0] S_EOUT = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  edge_reg, edge_next;
    logic [63:0] occ_reg, occ_next;
    logic [63:0] open_reg, open_next;
    logic [63:0] closed_reg, closed_next;
    logic [6:0]  ins_reg, ins_next;
    logic [6:0]  idx_reg, idx_next;
    logic        pv_reg, pv_next;
    logic [5:0]  pc_reg, pc_next;
    logic        bv_reg, bv_next;
    logic [5:0]  bc_reg, bc_next;
    logic [14:0] bf_reg, bf_next;
    logic [5:0]  bo_reg, bo_next;
    logic [13:0] bg_reg, bg_next;
    logic [5:0]  cur_reg, cur_next;
    logic [13:0] cg_reg, cg_next;
    logic [1:0]  d_reg, d_next;
    logic [5:0]  ni_reg, ni_next;
    logic [5:0]  si_reg, si_next;
    logic [5:0]  gi_reg, gi_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [5:0]  ri_reg, ri_next;
    logic        val_reg, val_next;
    gap_pkg::out_t res_reg, res_next;

    logic          rec_we;
    logic [5:0]    rec_wa, rec_ra;
    gap_pkg::rec_t rec_wd, rec_rd;
    logic          pth_we;
    logic [5:0]    pth_wa, pth_ra, pth_rd;

    gap_ram #(.W($bits(gap_pkg::rec_t)), .AW(gap_pkg::CELL_AW)) u_rec (
        .clk(clk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd),
        .raddr(rec_ra), .rdata(rec_rd)
    );

    gap_ram #(.W(gap_pkg::CELL_AW), .AW(gap_pkg::CELL_AW)) u_path (
        .clk(clk), .we(pth_we), .waddr(pth_wa), .wdata(cur_reg),
        .raddr(pth_ra), .rdata(pth_rd)
    );

    assign pready = 1'b1;
    assign prdata = (paddr == gap_pkg::ADDR_EDGE_COST) ? {24'b0, edge_reg} : 32'b0;
    assign busy   = (state_reg != S_IDLE);
    assign valid  = val_reg;
    assign res    = res_reg;

    logic [2:0]  cx, cy, nx, ny, px, py;
    logic        nok, pok, take;
    logic [13:0] ng;
    logic [5:0]  rbc, rbo;
    logic [14:0] rbf;
    logic [13:0] rbg;
    logic        rbv;

    always_comb
    begin
        cx = cur_reg[2:0];
        cy = cur_reg[5:3];
        nx = cx;
        ny = cy;
        nok = 1'b0;
        px = cx;
        py = cy;
        pok = 1'b0;
        unique case (d_reg)
            gap_pkg::DIR_XM:
            begin
                nx = cx - 3'd1;
                nok = (cx != 3'd0);
            end
            gap_pkg::DIR_YM:
            begin
                ny = cy - 3'd1;
                nok = (cy != 3'd0);
            end
            gap_pkg::DIR_XP:
            begin
                nx = cx + 3'd1;
                nok = ({1'b0, cx} + 4'd1) < gap_pkg::GRID_LIM;
            end
            default:
            begin
                ny = cy + 3'd1;
                nok = ({1'b0, cy} + 4'd1) < gap_pkg::GRID_LIM;
            end
        endcase
        unique case (rec_rd.dir)
            gap_pkg::DIR_XM:
            begin
                px = cx + 3'd1;
                pok = ({1'b0, cx} + 4'd1) < gap_pkg::GRID_LIM;
            end
            gap_pkg::DIR_YM:
            begin
                py = cy + 3'd1;
                pok = ({1'b0, cy} + 4'd1) < gap_pkg::GRID_LIM;
            end
            gap_pkg::DIR_XP:
            begin
                px = cx - 3'd1;
                pok = (cx != 3'd0);
            end
            default:
            begin
                py = cy - 3'd1;
                pok = (cy != 3'd0);
            end
        endcase
        ng = cg_reg + {6'b0, edge_reg};
        take = pv_reg && (!bv_reg || (rec_rd.f < bf_reg) ||
                          ((rec_rd.f == bf_reg) && (rec_rd.ord < bo_reg)));
        rbv = bv_reg || take;
        rbc = take ? pc_reg : bc_reg;
        rbf = take ? rec_rd.f : bf_reg;
        rbo = take ? rec_rd.ord : bo_reg;
        rbg = take ? rec_rd.g : bg_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        edge_next = edge_reg;
        occ_next = occ_reg;
        open_next = open_reg;
        closed_next = closed_reg;
        ins_next = ins_reg;
        idx_next = idx_reg;
        pv_next = 1'b0;
        pc_next = idx_reg[5:0];
        bv_next = bv_reg;
        bc_next = bc_reg;
        bf_next = bf_reg;
        bo_next = bo_reg;
        bg_next = bg_reg;
        cur_next = cur_reg;
        cg_next = cg_reg;
        d_next = d_reg;
        ni_next = ni_reg;
        si_next = si_reg;
        gi_next = gi_reg;
        cnt_next = cnt_reg;
        ri_next = ri_reg;
        val_next = 1'b0;
        res_next = res_reg;
        rec_we = 1'b0;
        rec_wa = ni_reg;
        rec_wd = '0;
        rec_ra = ni_reg;
        pth_we = 1'b0;
        pth_wa = cnt_reg[5:0];
        pth_ra = ri_reg;

        if (psel && penable && pwrite && (paddr == gap_pkg::ADDR_EDGE_COST))
        begin
            edge_next = pwdata[7:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.req_type == gap_pkg::REQ_WRITE)
                    begin
                        if (({1'b0, req.cell_x} < gap_pkg::GRID_LIM) &&
                            ({1'b0, req.cell_y} < gap_pkg::GRID_LIM))
                        begin
                            occ_next[{req.cell_y, req.cell_x}] = req.blocked;
                        end
                    end
                    else if (({1'b0, req.start_x} >= gap_pkg::GRID_LIM) ||
                             ({1'b0, req.start_y} >= gap_pkg::GRID_LIM) ||
                             ({1'b0, req.goal_x} >= gap_pkg::GRID_LIM) ||
                             ({1'b0, req.goal_y} >= gap_pkg::GRID_LIM))
                    begin
                        val_next = 1'b1;
                        res_next = '{pos_x: 3'd0, pos_y: 3'd0, found: 1'b0, last: 1'b1};
                    end
                    else if ((req.start_x == req.goal_x) && (req.start_y == req.goal_y))
                    begin
                        val_next = 1'b1;
                        res_next = '{pos_x: req.start_x, pos_y: req.start_y,
                                     found: 1'b1, last: 1'b1};
                    end
                    else
                    begin
                        si_next = {req.start_y, req.start_x};
                        gi_next = {req.goal_y, req.goal_x};
                        open_next = '0;
                        closed_next = '0;
                        open_next[{req.start_y, req.start_x}] = 1'b1;
                        rec_we = 1'b1;
                        rec_wa = {req.start_y, req.start_x};
                        rec_wd = '{g: 14'd0,
                                   f: gap_pkg::heur(req.start_x, req.start_y,
                                                    req.goal_x, req.goal_y, edge_reg),
                                   dir: gap_pkg::DIR_XM, ord: 6'd0};
                        ins_next = 7'd1;
                        idx_next = '0;
                        bv_next = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rec_ra = idx_reg[5:0];
                pv_next = !idx_reg[6] && open_reg[idx_reg[5:0]];
                bv_next = rbv;
                bc_next = rbc;
                bf_next = rbf;
                bo_next = rbo;
                bg_next = rbg;
                if (idx_reg[6])
                begin
                    pv_next = 1'b0;
                    if (!rbv)
                    begin
                        val_next = 1'b1;
                        res_next = '{pos_x: 3'd0, pos_y: 3'd0, found: 1'b0, last: 1'b1};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        open_next[rbc] = 1'b0;
                        closed_next[rbc] = 1'b1;
                        cur_next = rbc;
                        cg_next = rbg;
                        d_next = gap_pkg::DIR_XM;
                        state_next = S_NBR;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 7'd1;
                end
            end
            S_NBR:
            begin
                ni_next = {ny, nx};
                rec_ra = {ny, nx};
                if (nok && !occ_reg[{ny, nx}] && !closed_reg[{ny, nx}])
                begin
                    state_next = S_NUPD;
                end
                else if (d_reg == gap_pkg::DIR_YP)
                begin
                    idx_next = '0;
                    bv_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    d_next = d_reg + 2'd1;
                end
            end
            S_NUPD:
            begin
                if (d_reg == gap_pkg::DIR_YP)
                begin
                    idx_next = '0;
                    bv_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    d_next = d_reg + 2'd1;
                    state_next = S_NBR;
                end
                if (!open_reg[ni_reg])
                begin
                    rec_we = 1'b1;
                    rec_wd = '{g: ng,
                               f: {1'b0, ng} + gap_pkg::heur(ni_reg[2:0], ni_reg[5:3],
                                                             gi_reg[2:0], gi_reg[5:3],
                                                             edge_reg),
                               dir: d_reg, ord: ins_reg[5:0]};
                    ins_next = ins_reg + 7'd1;
                    open_next[ni_reg] = 1'b1;
                    if (ni_reg == gi_reg)
                    begin
                        cur_next = gi_reg;
                        cnt_next = '0;
                        state_next = S_TWR;
                    end
                end
                else if (ng < rec_rd.g)
                begin
                    rec_we = 1'b1;
                    rec_wd = '{g: ng,
                               f: rec_rd.f - {1'b0, rec_rd.g} + {1'b0, ng},
                               dir: d_reg, ord: rec_rd.ord};
                end
            end
            S_TWR:
            begin
                pth_we = 1'b1;
                rec_ra = cur_reg;
                cnt_next = cnt_reg + 7'd1;
                if ((cur_reg == si_reg) || (cnt_reg == 7'(gap_pkg::CELLS - 1)))
                begin
                    ri_next = cnt_reg[5:0];
                    state_next = S_ERD;
                end
                else
                begin
                    state_next = S_TRD;
                end
            end
            S_TRD:
            begin
                if (pok)
                begin
                    cur_next = {py, px};
                    state_next = S_TWR;
                end
                else
                begin
                    ri_next = 6'(cnt_reg - 7'd1);
                    state_next = S_ERD;
                end
            end
            S_ERD:
            begin
                state_next = S_EOUT;
            end
            default:
            begin
                val_next = 1'b1;
                res_next = '{pos_x: pth_rd[2:0], pos_y: pth_rd[5:3], found: 1'b1,
                             last: (ri_reg == 6'd0)};
                if (ri_reg == 6'd0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ri_next = ri_reg - 6'd1;
                    state_next = S_ERD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            edge_reg <= gap_pkg::EDGE_COST_RST;
            occ_reg <= '0;
            open_reg <= '0;
            closed_reg <= '0;
            ins_reg <= '0;
            idx_reg <= '0;
            pv_reg <= 1'b0;
            bv_reg <= 1'b0;
            val_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            edge_reg <= edge_next;
            occ_reg <= occ_next;
            open_reg <= open_next;
            closed_reg <= closed_next;
            ins_reg <= ins_next;
            idx_reg <= idx_next;
            pv_reg <= pv_next;
            bv_reg <= bv_next;
            val_reg <= val_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg <= pc_next;
        bc_reg <= bc_next;
        bf_reg <= bf_next;
        bo_reg <= bo_next;
        bg_reg <= bg_next;
        cur_reg <= cur_next;
        cg_reg <= cg_next;
        d_reg <= d_next;
        ni_reg <= ni_next;
        si_reg <= si_next;
        gi_reg <= gi_next;
        cnt_reg <= cnt_next;
        ri_reg <= ri_next;
        res_reg <= res_next;
    end
endmodule
